/* rtl/dlf_pkg.sv */
// dlf_pkg: shared types, constants and helpers for the dpll loop filter / nco block
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package dlf_pkg;

  localparam int PHASE_W = 32;
  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 24;
  localparam int PROD_W  = GAIN_W + ERR_W;   // coefficient times error
  localparam int TERM_W  = PROD_W - 4;       // after the divide by 16
  localparam int INTEG_W = 48;
  localparam int FSUM_W  = INTEG_W + 3;      // headroom for the frequency sum
  localparam int MAG_W   = ERR_W + 1;
  localparam int MAGW_W  = 27;               // |e| * 655
  localparam int SQ_W    = 31;
  localparam int LVL_W   = 16;
  localparam int CNT_W   = 16;
  localparam int AVG_W   = 33;

  localparam logic [9:0]        AVG_WEIGHT = 10'd655;
  localparam logic [LVL_W-1:0]  AVG_KEEP   = 16'd64881;  // 65536 - 655
  localparam logic [AVG_W-1:0]  AVG_ROUND  = 33'd32768;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;
  localparam logic [CNT_W-1:0]  LOCK_NEEDED_RST = 16'd16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_NEEDED    = 3'd5;
  localparam int CFG_DATA_W = 32;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [ERR_W-1:0]  phase_err;
  } dlf_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] freq_word;
    logic [PHASE_W-1:0] nco_phase;
    logic [LVL_W-1:0]   lock_level;
    logic               locked;
  } dlf_out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] second_gain;
    logic [PHASE_W-1:0]       nominal_step;
    logic [SQ_W-1:0]          lock_threshold;
    logic [CNT_W-1:0]         lock_needed;
  } dlf_cfg_t;

  // products stage to loop stage
  typedef struct packed {
    logic                     command;
    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_b;
    logic signed [TERM_W-1:0] term_g;
    logic [MAGW_W-1:0]        mag_w;
    logic [SQ_W-1:0]          sq;
  } dlf_term_t;

  // loop stage to nco stage
  typedef struct packed {
    logic               command;
    logic [PHASE_W-1:0] freq_word;
    logic [LVL_W-1:0]   lock_level;
    logic               locked;
  } dlf_loop_t;

  function automatic logic signed [INTEG_W-1:0] sat_integ(
    input logic signed [INTEG_W:0] x
  );
    logic signed [INTEG_W-1:0] r;
    if (x[INTEG_W] != x[INTEG_W-1]) begin
      r = x[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      r = x[INTEG_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/dlf_gain_mult.sv */
// dlf_gain_mult: input register and gain products stage
// depends on dlf_pkg
`timescale 1ns / 1ps

module dlf_gain_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dlf_pkg::dlf_in_t    in_data,
  input  dlf_pkg::dlf_cfg_t   cfg,
  input  logic                nxt_ready,
  output logic                term_valid,
  output dlf_pkg::dlf_term_t  term
);

  logic               in_valid_r;
  dlf_pkg::dlf_in_t   in_r;
  logic               term_valid_r;
  dlf_pkg::dlf_term_t term_r;
  dlf_pkg::dlf_term_t term_nxt;
  logic               s2_ready;
  logic               s1_ready;

  logic signed [dlf_pkg::PROD_W-1:0] prod_p, prod_b, prod_g;
  logic signed [dlf_pkg::MAG_W-1:0]  err_ext;
  logic [dlf_pkg::MAG_W-1:0]         mag;

  assign s2_ready = !term_valid_r || nxt_ready;
  assign s1_ready = !in_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    prod_p  = cfg.prop_gain   * in_r.phase_err;
    prod_b  = cfg.integ_gain  * in_r.phase_err;
    prod_g  = cfg.second_gain * in_r.phase_err;
    err_ext = dlf_pkg::MAG_W'(in_r.phase_err);
    mag     = err_ext[dlf_pkg::MAG_W-1] ? dlf_pkg::MAG_W'(-err_ext) : err_ext;

    term_nxt.command = in_r.command;
    // floor divide by 16 is the arithmetic shift
    term_nxt.term_p  = prod_p[dlf_pkg::PROD_W-1:4];
    term_nxt.term_b  = prod_b[dlf_pkg::PROD_W-1:4];
    term_nxt.term_g  = prod_g[dlf_pkg::PROD_W-1:4];
    term_nxt.mag_w   = dlf_pkg::MAGW_W'(mag) * dlf_pkg::MAGW_W'(dlf_pkg::AVG_WEIGHT);
    term_nxt.sq      = dlf_pkg::SQ_W'(dlf_pkg::SQ_W'(mag) * dlf_pkg::SQ_W'(mag));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      term_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_r <= in_valid;
      end
      if (s2_ready) begin
        term_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      in_r <= in_data;
    end
    if (s2_ready && in_valid_r) begin
      term_r <= term_nxt;
    end
  end

  assign term_valid = term_valid_r;
  assign term       = term_r;

endmodule

/* rtl/dlf_loop_update.sv */
// dlf_loop_update: loop filter state, frequency word, error average and lock count
// depends on dlf_pkg
`timescale 1ns / 1ps

module dlf_loop_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                term_valid,
  output logic                term_ready,
  input  dlf_pkg::dlf_term_t  term,
  input  dlf_pkg::dlf_cfg_t   cfg,
  input  logic                nxt_ready,
  output logic                loop_valid,
  output dlf_pkg::dlf_loop_t  loop
);

  logic signed [dlf_pkg::INTEG_W-1:0] int1_r, int1_nxt;
  logic signed [dlf_pkg::INTEG_W-1:0] int2_r, int2_nxt;
  logic [dlf_pkg::PHASE_W-1:0]        fw_r, fw_nxt;
  logic [dlf_pkg::LVL_W-1:0]          avg_r, avg_nxt;
  logic [dlf_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               loop_valid_r;
  dlf_pkg::dlf_loop_t                 loop_r, loop_nxt;

  logic signed [dlf_pkg::INTEG_W:0]  int1_sum, int2_sum;
  logic signed [dlf_pkg::INTEG_W-1:0] int1_upd, int2_upd;
  logic signed [dlf_pkg::FSUM_W-1:0] f_sum;
  logic [dlf_pkg::PHASE_W-1:0]       f_clamp;
  logic [dlf_pkg::AVG_W-1:0]         avg_sum;
  logic [dlf_pkg::CNT_W-1:0]         cnt_inc;
  logic                              small_err;
  logic                              load;

  assign term_ready = !loop_valid_r || nxt_ready;
  assign load       = term_valid && term_ready;

  always_comb begin
    int1_sum = (dlf_pkg::INTEG_W + 1)'(int1_r) + (dlf_pkg::INTEG_W + 1)'(term.term_b);
    int2_sum = (dlf_pkg::INTEG_W + 1)'(int2_r) + (dlf_pkg::INTEG_W + 1)'(term.term_g);
    int1_upd = dlf_pkg::sat_integ(int1_sum);
    int2_upd = dlf_pkg::sat_integ(int2_sum);

    f_sum = dlf_pkg::FSUM_W'(fw_r) + dlf_pkg::FSUM_W'(term.term_p)
          + dlf_pkg::FSUM_W'(int1_upd) + dlf_pkg::FSUM_W'(int2_upd);
    // clamp at zero, saturate at full scale
    if (f_sum[dlf_pkg::FSUM_W-1]) begin
      f_clamp = '0;
    end else if (|f_sum[dlf_pkg::FSUM_W-2:dlf_pkg::PHASE_W]) begin
      f_clamp = '1;
    end else begin
      f_clamp = f_sum[dlf_pkg::PHASE_W-1:0];
    end

    avg_sum = dlf_pkg::AVG_W'(avg_r) * dlf_pkg::AVG_W'(dlf_pkg::AVG_KEEP)
            + dlf_pkg::AVG_W'(term.mag_w) + dlf_pkg::AVG_ROUND;

    small_err = term.sq < cfg.lock_threshold;
    cnt_inc   = (cnt_r == dlf_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;

    loop_nxt.command = term.command;
    if (term.command == dlf_pkg::CMD_REINIT) begin
      int1_nxt = '0;
      int2_nxt = '0;
      fw_nxt   = cfg.nominal_step;
      avg_nxt  = '0;
      cnt_nxt  = '0;
      loop_nxt.locked = 1'b0;
    end else begin
      int1_nxt = int1_upd;
      int2_nxt = int2_upd;
      fw_nxt   = f_clamp;
      avg_nxt  = avg_sum[dlf_pkg::LVL_W+15:16];
      cnt_nxt  = small_err ? cnt_inc : '0;
      loop_nxt.locked = small_err && (cnt_inc >= cfg.lock_needed);
    end
    loop_nxt.freq_word  = fw_nxt;
    loop_nxt.lock_level = avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int1_r       <= '0;
      int2_r       <= '0;
      fw_r         <= '0;
      avg_r        <= '0;
      cnt_r        <= '0;
      loop_valid_r <= 1'b0;
    end else begin
      if (load) begin
        int1_r <= int1_nxt;
        int2_r <= int2_nxt;
        fw_r   <= fw_nxt;
        avg_r  <= avg_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (term_ready) begin
        loop_valid_r <= term_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      loop_r <= loop_nxt;
    end
  end

  assign loop_valid = loop_valid_r;
  assign loop       = loop_r;

endmodule

/* rtl/dlf_nco.sv */
// dlf_nco: wrapping phase accumulator and result register
// depends on dlf_pkg
`timescale 1ns / 1ps

module dlf_nco (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                loop_valid,
  output logic                loop_ready,
  input  dlf_pkg::dlf_loop_t  loop,
  output logic                out_valid,
  input  logic                out_stall,
  output dlf_pkg::dlf_out_t   out_data
);

  logic [dlf_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        out_valid_r;
  dlf_pkg::dlf_out_t           out_r, out_nxt;
  logic                        load;

  assign loop_ready = !out_valid_r || !out_stall;
  assign load       = loop_valid && loop_ready;

  always_comb begin
    if (loop.command == dlf_pkg::CMD_REINIT) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_r + loop.freq_word;
    end
    out_nxt.freq_word  = loop.freq_word;
    out_nxt.nco_phase  = phase_nxt;
    out_nxt.lock_level = loop.lock_level;
    out_nxt.locked     = loop.locked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r <= phase_nxt;
      end
      if (loop_ready) begin
        out_valid_r <= loop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/dpll_loop_filter_nco_lock.sv */
// path: a request passes through the request, products, loop and result registers in turn
// throughput: one request per cycle while the result side does not stall, set by the integrator and
//   frequency word update in the loop stage
// reset (synchronous, rst_n low): registers to their defaults, loop state cleared,
//   frequency word 0, lock_needed 16, pipeline emptied
// depends on dlf_pkg, dlf_gain_mult, dlf_loop_update, dlf_nco
`timescale 1ns / 1ps

module dpll_loop_filter_nco_lock (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dlf_pkg::dlf_in_t                   in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output dlf_pkg::dlf_out_t                  out_data,
  // register write port
  input  logic                               cfg_we,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // pipeline:
  //   stage 1  request register
  //   stage 2  three gain products (divided by 16), |e| weighted and e squared
  //   stage 3  integrators with saturation, frequency word sum and clamp,
  //            error average and small-error count (the loop state lives here)
  //   stage 4  phase accumulator and result register
  // each stage takes a new request whenever it is empty or its successor
  // moves on, so bubbles close up while the result side stalls

  dlf_pkg::dlf_cfg_t  cfg_r, cfg_nxt;
  logic               term_valid, term_ready;
  dlf_pkg::dlf_term_t term;
  logic               loop_valid, loop_ready;
  dlf_pkg::dlf_loop_t loop;

  // register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dlf_pkg::REG_PROP_GAIN:      cfg_nxt.prop_gain      = cfg_wdata[dlf_pkg::GAIN_W-1:0];
        dlf_pkg::REG_INTEG_GAIN:     cfg_nxt.integ_gain     = cfg_wdata[dlf_pkg::GAIN_W-1:0];
        dlf_pkg::REG_SECOND_GAIN:    cfg_nxt.second_gain    = cfg_wdata[dlf_pkg::GAIN_W-1:0];
        dlf_pkg::REG_NOMINAL_STEP:   cfg_nxt.nominal_step   = cfg_wdata[dlf_pkg::PHASE_W-1:0];
        dlf_pkg::REG_LOCK_THRESHOLD: cfg_nxt.lock_threshold = cfg_wdata[dlf_pkg::SQ_W-1:0];
        dlf_pkg::REG_LOCK_NEEDED:    cfg_nxt.lock_needed    = cfg_wdata[dlf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= '0;
      cfg_r.integ_gain     <= '0;
      cfg_r.second_gain    <= '0;
      cfg_r.nominal_step   <= '0;
      cfg_r.lock_threshold <= '0;
      cfg_r.lock_needed    <= dlf_pkg::LOCK_NEEDED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stages 1 and 2
  dlf_gain_mult u_gain_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .nxt_ready  (term_ready),
    .term_valid (term_valid),
    .term       (term)
  );

  // stage 3: reinit requests also clear the loop state here
  dlf_loop_update u_loop_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term),
    .cfg        (cfg_r),
    .nxt_ready  (loop_ready),
    .loop_valid (loop_valid),
    .loop       (loop)
  );

  // stage 4: result register parts the two channels
  dlf_nco u_nco (
    .clk        (clk),
    .rst_n      (rst_n),
    .loop_valid (loop_valid),
    .loop_ready (loop_ready),
    .loop       (loop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* rtl/dlf_checker.sv */
// dlf_checker: port-level checks for the dpll loop filter / nco block, bound to the top
// depends on dlf_pkg
`timescale 1ns / 1ps

module dlf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input dlf_pkg::dlf_out_t              out_data
);

  localparam logic [2:0] DEPTH = 3'd4;

  logic [2:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result without an outstanding request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result with no request outstanding");

  // the pipeline never holds more than its four stages
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= DEPTH)
    else $error("more requests in flight than stages");

  // the error average stays within the magnitude range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lock_level <= 16'd32768)
    else $error("lock level out of range");

endmodule

bind dpll_loop_filter_nco_lock dlf_checker u_dlf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
